// ----- rtl/matrix_inverse_3x3_defines.svh -----
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix inverse check failed");

// Consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix inverse check failed");

`endif

// ----- rtl/mi3_pkg.sv -----
// Shared constants and types for the 3x3 matrix inverse block.
// No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int N_ELEM         = 9;

  typedef logic [3:0] idx_t;

  // Cofactor i = e[a]*e[b] - e[c]*e[d], indices into the row-major matrix.
  // Entries are already transposed, so cofactor i is inverse element i.
  localparam idx_t COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic zero;
    logic sat;
  } mi3_flags_t;

endpackage

// ----- rtl/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by adjugate, fixed point, one matrix per beat.
// Depends on mi3_pkg, mi3_cof, mi3_det, mi3_div and matrix_inverse_3x3_defines.svh.
//
//   channel | handshake                    | payload
//   in      | in_valid / in_stall          | m00 .. m22
//   out     | out_valid / out_stall        | inv00 .. inv22, singular, clipped
//
// One beat enters every cycle while in_stall is low.
// The depth is set by the divider lanes, which resolve one quotient bit per stage.
// Reset clears only the valid chain; payload registers are not reset.
// A stalled result freezes the whole pipeline; while the last stage is empty or drains,
// new beats are still accepted.
`timescale 1ns / 1ps
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  m00,
  input  logic signed [DATA_WIDTH-1:0]  m01,
  input  logic signed [DATA_WIDTH-1:0]  m02,
  input  logic signed [DATA_WIDTH-1:0]  m10,
  input  logic signed [DATA_WIDTH-1:0]  m11,
  input  logic signed [DATA_WIDTH-1:0]  m12,
  input  logic signed [DATA_WIDTH-1:0]  m20,
  input  logic signed [DATA_WIDTH-1:0]  m21,
  input  logic signed [DATA_WIDTH-1:0]  m22,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  inv00,
  output logic signed [DATA_WIDTH-1:0]  inv01,
  output logic signed [DATA_WIDTH-1:0]  inv02,
  output logic signed [DATA_WIDTH-1:0]  inv10,
  output logic signed [DATA_WIDTH-1:0]  inv11,
  output logic signed [DATA_WIDTH-1:0]  inv12,
  output logic signed [DATA_WIDTH-1:0]  inv20,
  output logic signed [DATA_WIDTH-1:0]  inv21,
  output logic signed [DATA_WIDTH-1:0]  inv22,
  output logic                          singular,
  output logic                          clipped
);

  localparam int W     = DATA_WIDTH;
  localparam int CW    = 2*W+1;
  localparam int DW    = 3*W+3;
  localparam int NE    = mi3_pkg::N_ELEM;
  // Two cofactor stages, two determinant stages, then the divider lanes.
  localparam int DEPTH = 4 + W + 3;

  // Pipeline control: the whole pipe advances unless a finished beat is held.
  logic [DEPTH-1:0] vld;
  logic             en;

  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  logic signed [W-1:0] m_in [NE];

  assign m_in[0] = m00;
  assign m_in[1] = m01;
  assign m_in[2] = m02;
  assign m_in[3] = m10;
  assign m_in[4] = m11;
  assign m_in[5] = m12;
  assign m_in[6] = m20;
  assign m_in[7] = m21;
  assign m_in[8] = m22;

  // The first row is delayed to meet the cofactors at the determinant stage.
  logic signed [W-1:0] e_s1 [3];
  logic signed [W-1:0] e_s2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_s1[k] <= m_in[k];
        e_s2[k] <= e_s1[k];
      end
    end
  end

  // Nine cofactor lanes work side by side.
  logic signed [CW-1:0] cof    [NE];
  logic signed [CW-1:0] cof_s3 [NE];
  logic signed [CW-1:0] cof_s4 [NE];

  for (genvar i = 0; i < NE; i++) begin : g_cof
    mi3_cof #(.DATA_WIDTH(W)) u_cof (
      .clk (clk),
      .en  (en),
      .a   (m_in[mi3_pkg::COF_IDX[i][0]]),
      .b   (m_in[mi3_pkg::COF_IDX[i][1]]),
      .c   (m_in[mi3_pkg::COF_IDX[i][2]]),
      .d   (m_in[mi3_pkg::COF_IDX[i][3]]),
      .cof (cof[i])
    );
  end

  // Cofactors pass through cof_s3 and cof_s4 while the determinant is merged.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        cof_s3[k] <= cof[k];
        cof_s4[k] <= cof_s3[k];
      end
    end
  end

  logic signed [DW-1:0] det;

  mi3_det #(.DATA_WIDTH(W)) u_det (
    .clk (clk),
    .en  (en),
    .e0  (e_s2[0]),
    .e1  (e_s2[1]),
    .e2  (e_s2[2]),
    .c0  (cof[0]),
    .c1  (cof[3]),
    .c2  (cof[6]),
    .det (det)
  );

  // Nine divider lanes share the determinant; each handles one inverse element.
  logic signed [W-1:0]   q     [NE];
  mi3_pkg::mi3_flags_t   flags [NE];

  for (genvar i = 0; i < NE; i++) begin : g_div
    mi3_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .cof   (cof_s4[i]),
      .det   (det),
      .q     (q[i]),
      .flags (flags[i])
    );
  end

  // Merge: the clip flag is the OR of the lanes; singular is taken from lane 0, as all lanes share the determinant.
  logic clip_any;

  always_comb begin
    clip_any = 1'b0;
    for (int k = 0; k < NE; k++) begin
      clip_any = clip_any | flags[k].sat;
    end
  end

  assign inv00    = q[0];
  assign inv01    = q[1];
  assign inv02    = q[2];
  assign inv10    = q[3];
  assign inv11    = q[4];
  assign inv12    = q[5];
  assign inv20    = q[6];
  assign inv21    = q[7];
  assign inv22    = q[8];
  assign singular = flags[0].zero;
  assign clipped  = clip_any;

  // A singular matrix yields an all-zero inverse and never reports clipping.
  `MI3_ASSERT_NOW(a_singular_zero, out_valid && singular, !clipped && inv00 == '0 && inv11 == '0 && inv22 == '0)
  // The input side only stalls behind a held result.
  `MI3_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // A held result is still present in the next cycle.
  `MI3_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)

endmodule

// ----- rtl/mi3_cof.sv -----
// One cofactor lane: two products in the first stage, their difference in the second.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module mi3_cof #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [DATA_WIDTH-1:0]  a,
  input  logic signed [DATA_WIDTH-1:0]  b,
  input  logic signed [DATA_WIDTH-1:0]  c,
  input  logic signed [DATA_WIDTH-1:0]  d,
  output logic signed [2*DATA_WIDTH:0]  cof
);

  logic signed [2*DATA_WIDTH-1:0] pa;
  logic signed [2*DATA_WIDTH-1:0] pb;

  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= a * b;
      pb  <= c * d;
      cof <= (2*DATA_WIDTH+1)'(pa) - (2*DATA_WIDTH+1)'(pb);
    end
  end

endmodule

// ----- rtl/mi3_det.sv -----
// Determinant merge: first row times its cofactors, each product split in two halves.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module mi3_det #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [DATA_WIDTH-1:0]    e0,
  input  logic signed [DATA_WIDTH-1:0]    e1,
  input  logic signed [DATA_WIDTH-1:0]    e2,
  input  logic signed [2*DATA_WIDTH:0]    c0,
  input  logic signed [2*DATA_WIDTH:0]    c1,
  input  logic signed [2*DATA_WIDTH:0]    c2,
  output logic signed [3*DATA_WIDTH+2:0]  det
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = 3*W+3;

  logic signed [W-1:0]   e_v  [3];
  logic signed [2*W:0]   c_v  [3];
  logic signed [2*W:0]   plo  [3];
  logic signed [2*W:0]   phi  [3];
  logic signed [DW-1:0]  det_next;

  assign e_v[0] = e0;
  assign e_v[1] = e1;
  assign e_v[2] = e2;
  assign c_v[0] = c0;
  assign c_v[1] = c1;
  assign c_v[2] = c2;

  // The wide cofactor is cut into an unsigned low half and a signed high half.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plo[k] <= e_v[k] * $signed({1'b0, c_v[k][W-1:0]});
        phi[k] <= e_v[k] * $signed(c_v[k][2*W:W]);
      end
    end
  end

  always_comb begin
    det_next = '0;
    for (int k = 0; k < 3; k++) begin
      det_next = det_next + (DW'(phi[k]) <<< W) + DW'(plo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= det_next;
    end
  end

endmodule

// ----- rtl/mi3_div.sv -----
// Divider lane: scaled cofactor over determinant, one quotient bit per stage, then saturation.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [2*DATA_WIDTH:0]    cof,
  input  logic signed [3*DATA_WIDTH+2:0]  det,
  output logic signed [DATA_WIDTH-1:0]    q,
  output mi3_pkg::mi3_flags_t             flags
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = 2*W+1;
  localparam int DW = 3*W+3;
  localparam int NW = CW+2*FRAC_BITS;
  localparam int RW = (NW > DW+W) ? NW : DW+W;

  // Stage A: magnitudes and signs.
  logic [CW-1:0] mag_c;
  logic [DW-1:0] den_a;
  logic          neg_a;
  logic          zero_a;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_c  <= cof[CW-1] ? CW'(-(CW+1)'(cof)) : CW'(cof);
      den_a  <= det[DW-1] ? DW'(-(DW+1)'(det)) : DW'(det);
      neg_a  <= cof[CW-1] ^ det[DW-1];
      zero_a <= (det == '0);
    end
  end

  // Stage B onward: remainder, divisor and quotient travel down the stages.
  logic [RW-1:0] rem  [W+1];
  logic [W-1:0]  quo  [W+1];
  logic [DW-1:0] den  [W+1];
  logic          neg  [W+1];
  logic          zero [W+1];
  logic          ovf  [W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(mag_c) << (2*FRAC_BITS);
      quo[0]  <= '0;
      den[0]  <= den_a;
      neg[0]  <= neg_a;
      zero[0] <= zero_a;
      // A quotient of 2^W or more cannot fit in the result.
      ovf[0]  <= (RW'(mag_c) << (2*FRAC_BITS)) >= (RW'(den_a) << W);
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    localparam int B = W-1-i;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(den[i]) << B;
    assign take = (rem[i] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? rem[i] - dsh : rem[i];
        quo[i+1]  <= quo[i] | (take ? (W'(1) << B) : '0);
        den[i+1]  <= den[i];
        neg[i+1]  <= neg[i];
        zero[i+1] <= zero[i];
        ovf[i+1]  <= ovf[i];
      end
    end
  end

  localparam logic [W-1:0] HALF = W'(1) << (W-1);

  logic [W-1:0] mag;
  logic         sat;
  logic [W-1:0] val;

  always_comb begin
    mag = quo[W];
    if (neg[W]) begin
      sat = ovf[W] || (mag > HALF);
      val = sat ? HALF : W'(~mag + W'(1));
    end else begin
      sat = ovf[W] || (mag > HALF - W'(1));
      val = sat ? HALF - W'(1) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q          <= zero[W] ? '0 : $signed(val);
      flags.sat  <= sat && !zero[W];
      flags.zero <= zero[W];
    end
  end

endmodule
